### design/gf2d_pkg.sv
// shared types and constants for the gf2 polynomial divider
package gf2d_pkg;

	localparam int POLY_WIDTH_DEF = 32;
	localparam int DATA_W = 32;
	localparam logic [DATA_W-1:0] DIVISOR_RST = 32'd3;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_DIV_ZERO = 2'd1,
		STAT_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRE,
		ST_STEP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic pre;
		logic step;
	} cell_ctl_t;

endpackage

### design/gf2d_cell.sv
// one bit slice of the serial divider: remainder, feed, quotient and degree marker bits
module gf2d_cell import gf2d_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      msg_bit,
	input  logic      div_bit,
	input  logic      oh_bit,
	input  logic      s_lo,
	input  logic      f_lo,
	input  logic      q_lo,
	input  logic      mark_hi,
	input  logic      red,
	output logic      s,
	output logic      f,
	output logic      q,
	output logic      mark,
	output logic      tap
);

	logic s_q;
	logic f_q;
	logic q_q;
	logic mark_q;
	logic div_q;
	logic oh_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			s_q    <= 1'b0;
			q_q    <= 1'b0;
			f_q    <= msg_bit;
			div_q  <= div_bit;
			oh_q   <= oh_bit;
			mark_q <= oh_bit;
		end else if (ctl.pre) begin
			f_q    <= f_lo;
			mark_q <= mark_hi;
		end else if (ctl.step) begin
			f_q <= f_lo;
			s_q <= s_lo ^ (red & div_q);
			q_q <= q_lo;
		end
	end

	// shifted-in remainder bit at the divisor's leading position
	assign tap  = s_lo & oh_q;
	assign s    = s_q;
	assign f    = f_q;
	assign q    = q_q;
	assign mark = mark_q;

endmodule

### design/gf2d_ctrl.sv
// sequencer for the divider: load, optional pre-shift, division steps, handoff
module gf2d_ctrl import gf2d_pkg::*; #(
	parameter int POLY_WIDTH = POLY_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_fire,
	input  logic      div_zero,
	input  logic      pre_need,
	input  logic      f_top,
	input  logic      mark_last,
	input  logic      out_free,
	output cell_ctl_t ctl,
	output logic      idle,
	output logic      out_load,
	output status_t   status
);

	localparam int CNT_W = $clog2(POLY_WIDTH);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             ovf_q, ovf_d;
	status_t          status_q, status_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			status_q <= STAT_OK;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			ovf_q    <= ovf_d;
			status_q <= status_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		ovf_d    = ovf_q;
		status_d = status_q;
		ctl      = '0;
		idle     = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (in_fire) begin
					ctl.load = 1'b1;
					cnt_d    = '0;
					ovf_d    = 1'b0;
					if (div_zero) begin
						status_d = STAT_DIV_ZERO;
						state_d  = ST_DONE;
					end else begin
						status_d = STAT_OK;
						state_d  = pre_need ? ST_PRE : ST_STEP;
					end
				end
			end
			ST_PRE: begin
				ctl.pre = 1'b1;
				ovf_d   = ovf_q | f_top;
				if (mark_last) begin
					if (ovf_q | f_top) begin
						status_d = STAT_OVERFLOW;
						state_d  = ST_DONE;
					end else begin
						state_d = ST_STEP;
					end
				end
			end
			ST_STEP: begin
				ctl.step = 1'b1;
				cnt_d    = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(POLY_WIDTH - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign status = status_q;

endmodule

### design/gf2_polynomial_divider.sv
// top level of the gf2 polynomial divider with crc check verdict
// Divides the message by the divisor register in GF(2), one message bit per cycle in the step
// state, through a row of POLY_WIDTH bit cells (serial shift-and-reduce). With append_zeros
// set and divisor degree d above zero, the message is first pre-shifted by d places. A zero
// divisor goes straight to the done state, an overflow after the pre-shift. The result sits
// in an output register, so a new transaction is taken while it waits. The divisor resets to
// 3; the user writes it through cfg_we/cfg_wdata while idle, the block does not enforce it.
module gf2_polynomial_divider import gf2d_pkg::*; #(
	parameter int POLY_WIDTH = POLY_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [DATA_W-1:0]   cfg_wdata,      // divisor_poly
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [DATA_W-1:0]   s_axis_tdata,   // message
	input  logic [0:0]          s_axis_tuser,   // append_zeros
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [2*DATA_W-1:0] m_axis_tdata,   // quotient, remainder
	output logic [2:0]          m_axis_tuser    // check_pass, status
);

	localparam int PAD_W = POLY_WIDTH + DATA_W;

	logic [DATA_W-1:0]     divisor_q;
	logic [PAD_W-1:0]      msg_pad, div_pad, quo_pad, rem_pad;
	logic [POLY_WIDTH-1:0] msg_w, div_w, tm, oh;
	logic [POLY_WIDTH-1:0] s_v, f_v, q_v, mark_v, tap_v;
	logic [POLY_WIDTH-1:0] s_lo_v, f_lo_v, q_lo_v, mark_hi_v;
	logic                  red;
	logic                  in_fire;
	logic                  idle;
	logic                  out_load;
	logic                  out_free;
	cell_ctl_t             ctl;
	status_t               status;

	logic                  out_valid_q;
	logic [DATA_W-1:0]     quo_q, rem_q;
	logic                  pass_q;
	status_t               stat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q <= DIVISOR_RST;
		end else if (cfg_we) begin
			divisor_q <= cfg_wdata;
		end
	end

	assign msg_pad = PAD_W'(s_axis_tdata);
	assign div_pad = PAD_W'(divisor_q);
	assign msg_w   = msg_pad[POLY_WIDTH-1:0];
	assign div_w   = div_pad[POLY_WIDTH-1:0];

	// thermometer of bits at or below the leading one, then its one-hot edge
	always_comb begin
		for (int i = 0; i < POLY_WIDTH; i++) begin
			tm[i] = |(div_w >> i);
		end
	end
	assign oh = tm & ~(tm >> 1);

	assign s_axis_tready = idle;
	assign in_fire       = s_axis_tvalid & idle;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign s_lo_v    = {s_v[POLY_WIDTH-2:0], f_v[POLY_WIDTH-1]};
	assign f_lo_v    = {f_v[POLY_WIDTH-2:0], 1'b0};
	assign q_lo_v    = {q_v[POLY_WIDTH-2:0], red};
	assign mark_hi_v = {1'b0, mark_v[POLY_WIDTH-1:1]};
	assign red       = |tap_v;

	for (genvar i = 0; i < POLY_WIDTH; i++) begin : g_cell
		gf2d_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.msg_bit (msg_w[i]),
			.div_bit (div_w[i]),
			.oh_bit  (oh[i]),
			.s_lo    (s_lo_v[i]),
			.f_lo    (f_lo_v[i]),
			.q_lo    (q_lo_v[i]),
			.mark_hi (mark_hi_v[i]),
			.red     (red),
			.s       (s_v[i]),
			.f       (f_v[i]),
			.q       (q_v[i]),
			.mark    (mark_v[i]),
			.tap     (tap_v[i])
		);
	end

	gf2d_ctrl #(
		.POLY_WIDTH (POLY_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.div_zero  (~tm[0]),
		.pre_need  (s_axis_tuser[0] & ~oh[0]),
		.f_top     (f_v[POLY_WIDTH-1]),
		.mark_last (mark_v[1]),
		.out_free  (out_free),
		.ctl       (ctl),
		.idle      (idle),
		.out_load  (out_load),
		.status    (status)
	);

	assign quo_pad = PAD_W'(q_v);
	assign rem_pad = PAD_W'(s_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			stat_q <= status;
			if (status == STAT_OK) begin
				quo_q  <= quo_pad[DATA_W-1:0];
				rem_q  <= rem_pad[DATA_W-1:0];
				pass_q <= (s_v == '0);
			end else begin
				quo_q  <= '0;
				rem_q  <= '0;
				pass_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {rem_q, quo_q};
	assign m_axis_tuser  = {stat_q, pass_q};

	a_pass_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
			m_axis_tuser[2:1] == STAT_OK && m_axis_tdata[2*DATA_W-1:DATA_W] == '0)
		else $error("check_pass with error status or nonzero remainder");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2:1] != STAT_OK |-> m_axis_tdata == '0)
		else $error("error result carries nonzero quotient or remainder");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_axis_tready)
		else $error("divider accepted a transaction while busy");

	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_axis_tvalid && s_axis_tready)
		else $error("result handoff did not raise tvalid and return to idle");

endmodule
